// ----- rtl/isfp_pkg.sv -----
package isfp_pkg;

	localparam int FRAME_LEN = 11;

	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_RATE  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [7:0] TYPE_MAG   = 8'h54;

	typedef enum logic [2:0] {
		KIND_ACCEL = 3'd0,
		KIND_RATE  = 3'd1,
		KIND_ANGLE = 3'd2,
		KIND_MAG   = 3'd3,
		KIND_OTHER = 3'd4,
		KIND_BAD   = 3'd5
	} kind_t;

	typedef struct packed {
		logic               update;
		logic signed [15:0] z;
	} yaw_upd_t;

endpackage

// ----- rtl/isfp_if.sv -----
interface isfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface isfp_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [7:0]         type_byte;
	logic signed [15:0] word_x;
	logic signed [15:0] word_y;
	logic signed [15:0] word_z;
	logic signed [31:0] yaw_unwrapped;

	modport source (output valid, output kind, output type_byte, output word_x,
		output word_y, output word_z, output yaw_unwrapped, input ready);
	modport sink (input valid, input kind, input type_byte, input word_x,
		input word_y, input word_z, input yaw_unwrapped, output ready);
endinterface

// ----- rtl/isfp_yaw.sv -----
module isfp_yaw
	import isfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  yaw_upd_t           upd,
	output logic signed [31:0] yaw_next
);

	localparam logic signed [17:0] HALF_TURN = 18'sd32768;
	localparam logic signed [15:0] TURNS_MIN = 16'sh8000;
	localparam logic signed [15:0] TURNS_MAX = 16'sh7fff;

	logic signed [15:0] last_q;
	logic signed [15:0] turns_q;
	logic               unseeded_q;
	logic signed [17:0] delta;
	logic signed [15:0] turns_calc;
	logic signed [15:0] turns_nx;
	logic signed [15:0] last_nx;

	assign delta = {{2{upd.z[15]}}, upd.z} - {{2{last_q[15]}}, last_q};

	always_comb begin
		turns_calc = turns_q;
		if (!unseeded_q) begin
			if (delta > HALF_TURN) begin
				if (turns_q != TURNS_MIN)
					turns_calc = turns_q - 16'sd1;
			end else if (delta < -HALF_TURN) begin
				if (turns_q != TURNS_MAX)
					turns_calc = turns_q + 16'sd1;
			end
		end
	end

	assign turns_nx = upd.update ? turns_calc : turns_q;
	assign last_nx  = upd.update ? upd.z : last_q;
	assign yaw_next = {turns_nx, 16'h0000} + {{16{last_nx[15]}}, last_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			turns_q    <= '0;
			unseeded_q <= 1'b1;
		end else if (upd.update) begin
			last_q     <= last_nx;
			turns_q    <= turns_nx;
			unseeded_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/imu_serial_frame_parser.sv -----
// Parser for 11-byte serial sensor frames, one received byte per item.
// Input channel rx carries rx_byte; output channel frame carries kind,
// type_byte, the three little-endian signed words and the unwrapped yaw.
// The block hunts for the 0x55 header, collects type, eight data bytes and
// the checksum byte, and gives one result on the checksum byte.
// Throughput: one byte per cycle, set by the single input register stage,
// unless a checksum byte waits there on a full result register. A result is
// valid once its checksum byte has passed the input and result registers.
// Bad checksum: kind 5, words zero, yaw repeats the held value.
// Angle frames unwrap yaw with a saturating turn counter; the first angle
// frame after reset only seeds it.
// Reset clears framing, turn count and yaw reference; the first angle frame
// starts the unwrap.
// When the receiver stalls, the result register holds; a checksum byte then
// waits in the input register and rx.ready drops until the result is taken.
// Bytes that give no result keep flowing while the result register is full.
module imu_serial_frame_parser
	import isfp_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	isfp_in_if.sink     rx,
	isfp_out_if.source  frame
);

	localparam int            STORE_N  = FRAME_BYTES - 1;
	localparam int            CNT_W    = $clog2(FRAME_BYTES);
	localparam int            IDX_W    = $clog2(STORE_N);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STORE_N);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               recv_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [7:0]         sum_q;
	logic [7:0]         store_q [STORE_N];

	logic               out_valid_q;
	kind_t              kind_q;
	logic [7:0]         type_q;
	logic signed [15:0] wx_q;
	logic signed [15:0] wy_q;
	logic signed [15:0] wz_q;
	logic signed [31:0] yaw_q;

	logic               last_s1;
	logic               out_free;
	logic               adv;
	logic               load_out;
	logic               good;
	logic [7:0]         type_b;
	logic signed [15:0] wx;
	logic signed [15:0] wy;
	logic signed [15:0] wz;
	kind_t              kind_d;
	yaw_upd_t           upd;
	logic signed [31:0] yaw_next;

	assign last_s1  = recv_q && (cnt_q == CNT_LAST);
	assign out_free = !out_valid_q || frame.ready;
	assign adv      = valid_s1 && (!last_s1 || out_free);
	assign load_out = adv && last_s1;
	assign rx.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// framing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q <= 1'b0;
			cnt_q  <= '0;
			sum_q  <= '0;
		end else if (adv) begin
			if (!recv_q) begin
				if (byte_s1 == HDR_BYTE) begin
					recv_q <= 1'b1;
					cnt_q  <= CNT_W'(1);
					sum_q  <= byte_s1;
				end
			end else if (cnt_q != CNT_LAST) begin
				cnt_q <= cnt_q + CNT_W'(1);
				sum_q <= sum_q + byte_s1;
			end else begin
				recv_q <= 1'b0;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!recv_q) begin
				if (byte_s1 == HDR_BYTE)
					store_q[0] <= byte_s1;
			end else if (cnt_q != CNT_LAST) begin
				store_q[cnt_q[IDX_W-1:0]] <= byte_s1;
			end
		end
	end

	// frame decode
	assign good   = (sum_q == byte_s1);
	assign type_b = store_q[1];
	assign wx     = {store_q[3], store_q[2]};
	assign wy     = {store_q[5], store_q[4]};
	assign wz     = {store_q[7], store_q[6]};

	always_comb begin
		unique case (type_b)
			TYPE_ACCEL: kind_d = KIND_ACCEL;
			TYPE_RATE:  kind_d = KIND_RATE;
			TYPE_ANGLE: kind_d = KIND_ANGLE;
			TYPE_MAG:   kind_d = KIND_MAG;
			default:    kind_d = KIND_OTHER;
		endcase
		if (!good)
			kind_d = KIND_BAD;
	end

	assign upd.update = load_out && good && (type_b == TYPE_ANGLE);
	assign upd.z      = wz;

	isfp_yaw u_yaw (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.yaw_next (yaw_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q <= kind_d;
			type_q <= type_b;
			wx_q   <= good ? wx : '0;
			wy_q   <= good ? wy : '0;
			wz_q   <= good ? wz : '0;
			yaw_q  <= yaw_next;
		end
	end

	assign frame.valid         = out_valid_q;
	assign frame.kind          = kind_q;
	assign frame.type_byte     = type_q;
	assign frame.word_x        = wx_q;
	assign frame.word_y        = wy_q;
	assign frame.word_z        = wz_q;
	assign frame.yaw_unwrapped = yaw_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("byte count beyond frame");

	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!recv_q |-> cnt_q == '0)
		else $error("byte count set while hunting");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_BAD |-> wx_q == '0 && wy_q == '0 && wz_q == '0)
		else $error("words not cleared on checksum mismatch");

	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result without checksum byte");

endmodule
